// ===== design/uhtp_pkg.sv =====
// ----------------------------------------------------------------------------
// uhtp_pkg
// Shared types and constants for the UUID hex text parser.
// ----------------------------------------------------------------------------
package uhtp_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned ID_W        = 128;
   localparam int unsigned HALF_W      = 64;
   localparam int unsigned COUNT_W     = 6;
   localparam int unsigned DASH_W      = 3;
   localparam int unsigned NIBBLE_IDX_W = 5;

   localparam logic [COUNT_W-1:0] DIGITS_FULL = 6'd32;
   localparam logic [DASH_W-1:0]  MAX_DASHES  = 3'd4;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LC_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UC_F  = 8'h46;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_BAD_CHAR = 2'd1,
      ERR_DASHES   = 2'd2,
      ERR_LENGTH   = 2'd3
   } error_kind_type;

   // Classification of one character byte.
   typedef struct packed {
      logic       is_nul;
      logic       is_dash;
      logic       is_hex;
      logic [3:0] nibble;
   } char_class_type;

   // One finished result.
   typedef struct packed {
      logic [HALF_W-1:0] id_high;
      logic [HALF_W-1:0] id_low;
      logic              ok;
      error_kind_type    error_kind;
   } result_type;

endpackage

// ===== design/uhtp_char_decode.sv =====
// ----------------------------------------------------------------------------
// uhtp_char_decode
// Classifies a character byte: NUL, dash, hex digit (with its value) or other.
// ----------------------------------------------------------------------------
module uhtp_char_decode (
   input  logic [uhtp_pkg::CHAR_W-1:0] ch,
   output uhtp_pkg::char_class_type    cls
);

   logic is_dec;
   logic is_lc;
   logic is_uc;
   logic [uhtp_pkg::CHAR_W-1:0] diff_dec;
   logic [uhtp_pkg::CHAR_W-1:0] diff_lc;
   logic [uhtp_pkg::CHAR_W-1:0] diff_uc;

   assign is_dec = (ch >= uhtp_pkg::CHAR_0)    && (ch <= uhtp_pkg::CHAR_9);
   assign is_lc  = (ch >= uhtp_pkg::CHAR_LC_A) && (ch <= uhtp_pkg::CHAR_LC_F);
   assign is_uc  = (ch >= uhtp_pkg::CHAR_UC_A) && (ch <= uhtp_pkg::CHAR_UC_F);

   assign diff_dec = ch - uhtp_pkg::CHAR_0;
   assign diff_lc  = ch - uhtp_pkg::CHAR_LC_A + 8'd10;
   assign diff_uc  = ch - uhtp_pkg::CHAR_UC_A + 8'd10;

   always_comb begin
      cls.is_nul  = (ch == uhtp_pkg::CHAR_NUL);
      cls.is_dash = (ch == uhtp_pkg::CHAR_DASH);
      cls.is_hex  = is_dec || is_lc || is_uc;
      priority if (is_dec) begin
         cls.nibble = diff_dec[3:0];
      end else if (is_lc) begin
         cls.nibble = diff_lc[3:0];
      end else if (is_uc) begin
         cls.nibble = diff_uc[3:0];
      end else begin
         cls.nibble = 4'd0;
      end
   end

endmodule

// ===== design/uhtp_accum.sv =====
// ----------------------------------------------------------------------------
// uhtp_accum
// Parse state: packed identifier, digit and dash counts, sticky error.
// Updates once per stepped character and forms the result on NUL.
// ----------------------------------------------------------------------------
module uhtp_accum (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  uhtp_pkg::char_class_type cls,
   output uhtp_pkg::result_type     result
);

   logic [uhtp_pkg::ID_W-1:0]    id_ff,     id_in;
   logic [uhtp_pkg::COUNT_W-1:0] digits_ff, digits_in;
   logic [uhtp_pkg::DASH_W-1:0]  dashes_ff, dashes_in;
   uhtp_pkg::error_kind_type     error_ff,  error_in;

   logic                              busy_done;
   logic [uhtp_pkg::NIBBLE_IDX_W-1:0] nib_pos;
   uhtp_pkg::error_kind_type          final_err;

   // Full identifier or an earlier error freezes the state until NUL.
   assign busy_done = (error_ff != uhtp_pkg::ERR_NONE) || digits_ff[uhtp_pkg::COUNT_W-1];
   // First digit lands in the top nibble.
   assign nib_pos   = ~digits_ff[uhtp_pkg::NIBBLE_IDX_W-1:0];

   always_comb begin
      id_in     = id_ff;
      digits_in = digits_ff;
      dashes_in = dashes_ff;
      error_in  = error_ff;
      if (step) begin
         priority if (cls.is_nul) begin
            id_in     = '0;
            digits_in = '0;
            dashes_in = '0;
            error_in  = uhtp_pkg::ERR_NONE;
         end else if (busy_done) begin
            // ignored
         end else if (cls.is_dash) begin
            dashes_in = dashes_ff + 3'd1;
            if (dashes_ff == uhtp_pkg::MAX_DASHES) begin
               error_in = uhtp_pkg::ERR_DASHES;
            end
         end else if (!cls.is_hex) begin
            error_in = uhtp_pkg::ERR_BAD_CHAR;
         end else begin
            id_in[{nib_pos, 2'b00} +: 4] = cls.nibble;
            digits_in = digits_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff     <= '0;
         digits_ff <= '0;
         dashes_ff <= '0;
         error_ff  <= uhtp_pkg::ERR_NONE;
      end else begin
         id_ff     <= id_in;
         digits_ff <= digits_in;
         dashes_ff <= dashes_in;
         error_ff  <= error_in;
      end
   end

   always_comb begin
      if ((error_ff == uhtp_pkg::ERR_NONE) && (digits_ff != uhtp_pkg::DIGITS_FULL)) begin
         final_err = uhtp_pkg::ERR_LENGTH;
      end else begin
         final_err = error_ff;
      end
      result.id_high    = id_ff[uhtp_pkg::ID_W-1:uhtp_pkg::HALF_W];
      result.id_low     = id_ff[uhtp_pkg::HALF_W-1:0];
      result.ok         = (final_err == uhtp_pkg::ERR_NONE);
      result.error_kind = final_err;
   end

endmodule

// ===== design/uuid_hex_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// uuid_hex_text_parser_top
// Streams text bytes in, emits one parsed 128-bit identifier per NUL.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one character per transfer. Non-NUL bytes update the parse
//   state and give no result; a NUL closes the string and gives exactly one
//   rsp_ transfer with the identifier, rsp_ok and rsp_error_kind, after which
//   the state clears for the next string.
//   Throughput: one character per cycle, sustained, as long as results are
//   taken. Each byte is held in the input register, then the decode
//   and state update happen in a single pass into the state/result registers.
//   A transferred NUL reaches rsp_valid via the input and result registers.
//   Stall: the result register holds while rsp_ready is low. Plain bytes keep
//   flowing; a NUL waits in the input register until the result slot is free,
//   and req_ready drops only then.
//   Reset (synchronous, active high): empties both registers and clears the
//   parse state (zero identifier, no digits, no dashes, no error).
// ----------------------------------------------------------------------------
module uuid_hex_text_parser_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [uhtp_pkg::CHAR_W-1:0]         req_ch,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [uhtp_pkg::HALF_W-1:0]         rsp_id_high,
   output logic [uhtp_pkg::HALF_W-1:0]         rsp_id_low,
   output logic                                rsp_ok,
   output logic [1:0]                          rsp_error_kind
);

   // Input register
   logic                        in_vld_ff, in_vld_in;
   logic [uhtp_pkg::CHAR_W-1:0] in_ch_ff;

   // Result register
   logic                 rsp_vld_ff, rsp_vld_in;
   uhtp_pkg::result_type rsp_ff;

   uhtp_pkg::char_class_type cls;
   uhtp_pkg::result_type     result;
   logic                     slot_free;
   logic                     advance;
   logic                     emit;

   uhtp_char_decode u_decode (
      .ch  (in_ch_ff),
      .cls (cls)
   );

   // Result slot is free when empty or being drained this cycle.
   assign slot_free = !rsp_vld_ff || rsp_ready;
   // Plain bytes always move; a NUL needs the result slot.
   assign advance   = in_vld_ff && (!cls.is_nul || slot_free);
   assign emit      = advance && cls.is_nul;
   assign req_ready = !in_vld_ff || advance;

   uhtp_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cls    (cls),
      .result (result)
   );

   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !advance);
   assign rsp_vld_in = emit || (rsp_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ch_ff <= req_ch;
      end
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_id_high    = rsp_ff.id_high;
   assign rsp_id_low     = rsp_ff.id_low;
   assign rsp_ok         = rsp_ff.ok;
   assign rsp_error_kind = rsp_ff.error_kind;

endmodule

// ===== sim/uuid_hex_text_parser_top_test.sv =====
// ----------------------------------------------------------------------------
// uuid_hex_text_parser_top_test
// Self-checking bench for the UUID hex text parser. A short table of strings
// covers empty, bad-character, dash-overflow, short and full identifiers.
// Random strings follow, half well formed with random dash placement and
// trailing junk, plus short, broken and noise strings. Every result is
// checked against a typed value or the parse model, with random idling on both sides.
// ----------------------------------------------------------------------------
module uuid_hex_text_parser_top_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT   = 1500;  // at least this many characters are sent, NULs included
   localparam int STALL_LIMIT  = 200;   // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 8;     // settle time after the last result

   // ---------------------------------------------------------------------------
   // DUT ports
   // ---------------------------------------------------------------------------
   logic                        clock;
   logic                        reset       = 1'b1;
   logic                        req_valid   = 1'b0;
   logic                        req_ready;
   logic [uhtp_pkg::CHAR_W-1:0] req_ch      = '0;
   logic                        rsp_valid;
   logic                        rsp_ready   = 1'b0;
   logic [uhtp_pkg::HALF_W-1:0] rsp_id_high;
   logic [uhtp_pkg::HALF_W-1:0] rsp_id_low;
   logic                        rsp_ok;
   logic [1:0]                  rsp_error_kind;

   uuid_hex_text_parser_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_id_high    (rsp_id_high),
      .rsp_id_low     (rsp_id_low),
      .rsp_ok         (rsp_ok),
      .rsp_error_kind (rsp_error_kind)
   );

   // 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Parse model: shadow copy of the identifier being assembled
   // ---------------------------------------------------------------------------
   logic [uhtp_pkg::HALF_W-1:0]  acc_high   = '0;
   logic [uhtp_pkg::HALF_W-1:0]  acc_low    = '0;
   logic [uhtp_pkg::COUNT_W-1:0] acc_digits = '0;
   logic [uhtp_pkg::DASH_W-1:0]  acc_dashes = '0;
   uhtp_pkg::error_kind_type     acc_err    = uhtp_pkg::ERR_NONE;

   uhtp_pkg::result_type         ids_pending[$];   // identifiers still owed by the DUT
   logic [uhtp_pkg::CHAR_W-1:0]  text_q[$];        // characters of the string being built

   int  fail_count   = 0;
   int  sent_chars   = 0;   // characters transferred so far
   int  idle_cycles  = 0;
   bit  send_eager   = 1'b0; // sender runs back to back while set
   bit  take_eager   = 1'b0; // receiver never stalls while set

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_nibble(input logic [uhtp_pkg::CHAR_W-1:0] c);
      if (c >= uhtp_pkg::CHAR_0 && c <= uhtp_pkg::CHAR_9)
         return {1'b0, 4'(c - uhtp_pkg::CHAR_0)};
      if (c >= uhtp_pkg::CHAR_LC_A && c <= uhtp_pkg::CHAR_LC_F)
         return {1'b0, 4'(c - uhtp_pkg::CHAR_LC_A + 8'd10)};
      if (c >= uhtp_pkg::CHAR_UC_A && c <= uhtp_pkg::CHAR_UC_F)
         return {1'b0, 4'(c - uhtp_pkg::CHAR_UC_A + 8'd10)};
      return 5'h10;
   endfunction

   // One character through the model. A NUL closes the string and yields
   // the result; anything after an error or after 32 digits is dropped.
   function automatic void parse_char(input logic [uhtp_pkg::CHAR_W-1:0] c,
                                      output bit has_res,
                                      output uhtp_pkg::result_type res);
      logic [4:0]               nib;
      uhtp_pkg::error_kind_type kind;
      has_res = 1'b0;
      res     = '0;
      if (c == uhtp_pkg::CHAR_NUL) begin
         kind = acc_err;
         if (kind == uhtp_pkg::ERR_NONE && acc_digits != uhtp_pkg::DIGITS_FULL)
            kind = uhtp_pkg::ERR_LENGTH;
         res.id_high    = acc_high;
         res.id_low     = acc_low;
         res.ok         = (kind == uhtp_pkg::ERR_NONE);
         res.error_kind = kind;
         has_res        = 1'b1;
         acc_high       = '0;
         acc_low        = '0;
         acc_digits     = '0;
         acc_dashes     = '0;
         acc_err        = uhtp_pkg::ERR_NONE;
      end else if (acc_err != uhtp_pkg::ERR_NONE || acc_digits >= uhtp_pkg::DIGITS_FULL) begin
         // ignored
      end else if (c == uhtp_pkg::CHAR_DASH) begin
         acc_dashes = acc_dashes + 1'b1;
         if (acc_dashes > uhtp_pkg::MAX_DASHES) acc_err = uhtp_pkg::ERR_DASHES;
      end else begin
         nib = hex_nibble(c);
         if (nib[4]) begin
            acc_err = uhtp_pkg::ERR_BAD_CHAR;
         end else begin
            // first digit lands in the top nibble of the high half
            if (!acc_digits[4]) acc_high[4*(15-acc_digits[3:0]) +: 4] = nib[3:0];
            else                acc_low[4*(15-acc_digits[3:0]) +: 4]  = nib[3:0];
            acc_digits = acc_digits + 1'b1;
         end
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Sender: one character per call, optional hand-typed result for a NUL
   // ---------------------------------------------------------------------------
   task automatic push_char(input logic [uhtp_pkg::CHAR_W-1:0] c, input bit typed,
                            input uhtp_pkg::result_type want);
      int                   gap;
      bit                   has_res;
      uhtp_pkg::result_type res;
      gap = send_eager ? 0 : $urandom_range(0, 4);
      // valid is lowered only for a real gap, so back-to-back transfers keep it high
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      do @(posedge clock); while (!req_ready);
      parse_char(c, has_res, res);
      sent_chars++;
      if (has_res) begin
         ids_pending.push_back(typed ? want : res);
      end
   endtask

   task automatic push_text(input bit typed, input uhtp_pkg::result_type want);
      send_eager = ($urandom_range(0, 3) == 0);
      foreach (text_q[i]) push_char(text_q[i], 1'b0, '0);
      push_char(uhtp_pkg::CHAR_NUL, typed, want);
   endtask

   // hex digit; mode 0 forces '0', mode 1 forces 'f'/'F', else random value
   function automatic logic [uhtp_pkg::CHAR_W-1:0] hex_char(input int mode);
      int v;
      v = (mode == 0) ? 0 : (mode == 1) ? 15 : $urandom_range(0, 15);
      if (v < 10) return uhtp_pkg::CHAR_0 + 8'(v);
      return ($urandom_range(0, 1) ? uhtp_pkg::CHAR_UC_A : uhtp_pkg::CHAR_LC_A) + 8'(v - 10);
   endfunction

   function automatic logic [uhtp_pkg::CHAR_W-1:0] junk_char();
      logic [uhtp_pkg::CHAR_W-1:0] c;
      logic [4:0]                  nib;
      do begin
         c   = 8'($urandom_range(1, 255));
         nib = hex_nibble(c);
      end while (!nib[4] || c == uhtp_pkg::CHAR_DASH);
      return c;
   endfunction

   // Builds a string: ndig digits, ndash dashes in random slots (or in the
   // 8-4-4-4-12 positions), an optional bad character, then random tail bytes.
   task automatic build_text(input int ndig, input int ndash, input bit canonical,
                             input bit add_bad, input int n_tail);
      int dash_at[33];
      int bad_at;
      int mode;
      int i;
      text_q.delete();
      foreach (dash_at[j]) dash_at[j] = 0;
      if (canonical) begin
         dash_at[8] = 1; dash_at[12] = 1; dash_at[16] = 1; dash_at[20] = 1;
      end else begin
         for (i = 0; i < ndash; i++) dash_at[$urandom_range(0, ndig)]++;
      end
      bad_at = add_bad ? $urandom_range(0, ndig) : -1;
      mode   = $urandom_range(0, 5);
      for (i = 0; i <= ndig; i++) begin
         if (i == bad_at) text_q.push_back(junk_char());
         repeat (dash_at[i]) text_q.push_back(uhtp_pkg::CHAR_DASH);
         if (i < ndig) text_q.push_back(hex_char(mode));
      end
      repeat (n_tail) text_q.push_back(8'($urandom_range(1, 255)));
   endtask

   // ---------------------------------------------------------------------------
   // Directed strings. Expected results are typed in where obvious, the
   // rest are left to the parse model.
   // ---------------------------------------------------------------------------
   typedef struct {
      string                       text;
      bit                          typed;
      logic [uhtp_pkg::HALF_W-1:0] want_high;
      logic [uhtp_pkg::HALF_W-1:0] want_low;
      logic                        want_ok;
      uhtp_pkg::error_kind_type    want_err;
   } text_row_type;

   localparam int N_ROWS = 10;
   text_row_type text_rows[N_ROWS];

   initial begin
      // empty string: zero identifier, digit-count error
      text_rows[0] = '{"", 1'b1, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_LENGTH};
      text_rows[1] = '{"g", 1'b1, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_BAD_CHAR};
      // fifth dash trips the dash limit
      text_rows[2] = '{"-----", 1'b1, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_DASHES};
      text_rows[3] = '{"F0", 1'b1, 64'hF000_0000_0000_0000, 64'h0, 1'b0,
                       uhtp_pkg::ERR_LENGTH};
      text_rows[4] = '{"\377", 1'b1, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_BAD_CHAR};
      // bytes just outside the digit ranges, partial identifier kept
      text_rows[5] = '{"a1/7", 1'b0, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_NONE};
      text_rows[6] = '{"9:@", 1'b0, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_NONE};
      text_rows[7] = '{"Ea`G", 1'b0, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_NONE};
      // four dashes are fine, still short
      text_rows[8] = '{"1-2-3-4-5", 1'b0, 64'h0, 64'h0, 1'b0, uhtp_pkg::ERR_NONE};
      // full identifier, junk after the 32nd digit is dropped
      text_rows[9] = '{"ffffffffffffffffffffffffffffffffz-", 1'b1,
                       64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                       uhtp_pkg::ERR_NONE};
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      uhtp_pkg::result_type want;
      int                   kind;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (text_rows[r]) begin
         text_q.delete();
         for (int k = 0; k < text_rows[r].text.len(); k++)
            text_q.push_back(text_rows[r].text[k]);
         want.id_high    = text_rows[r].want_high;
         want.id_low     = text_rows[r].want_low;
         want.ok         = text_rows[r].want_ok;
         want.error_kind = text_rows[r].want_err;
         push_text(text_rows[r].typed, want);
      end

      // Random part: half well-formed identifiers, the rest short, dash
      // overflow, bad character or plain noise.
      while (sent_chars < ITEM_COUNT) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3, 4: begin
               build_text(32, $urandom_range(0, 4), $urandom_range(0, 2) == 0, 1'b0,
                          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
            end
            5, 6: begin
               build_text($urandom_range(0, 31), $urandom_range(0, 4), 1'b0, 1'b0, 0);
            end
            7: begin
               build_text($urandom_range(0, 32), $urandom_range(5, 7), 1'b0, 1'b0, 0);
            end
            8: begin
               build_text($urandom_range(0, 32), $urandom_range(0, 4), 1'b0, 1'b1,
                          $urandom_range(0, 4));
            end
            default: begin
               build_text(0, 0, 1'b0, 1'b0, $urandom_range(1, 20));
            end
         endcase
         push_text(1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain, then give a stray result a chance to show up
      while (ids_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ids_pending.size() != 0) begin
         $error("%0d identifiers never arrived", ids_pending.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, every result checked against the oldest
   // prediction
   // ---------------------------------------------------------------------------
   initial begin
      int                   stall;
      uhtp_pkg::result_type exp_id;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 7) == 0) take_eager = ~take_eager;
         stall = take_eager ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (ids_pending.size() == 0) begin
            $error("unexpected result: id %h_%h ok %0d error_kind %0d",
                   rsp_id_high, rsp_id_low, rsp_ok, rsp_error_kind);
            fail_count++;
         end else begin
            exp_id = ids_pending.pop_front();
            if (rsp_id_high !== exp_id.id_high) begin
               $error("id_high mismatch: expected %h, actual %h",
                      exp_id.id_high, rsp_id_high);
               fail_count++;
            end
            if (rsp_id_low !== exp_id.id_low) begin
               $error("id_low mismatch: expected %h, actual %h",
                      exp_id.id_low, rsp_id_low);
               fail_count++;
            end
            if (rsp_ok !== exp_id.ok) begin
               $error("ok mismatch: expected %0d, actual %0d", exp_id.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_error_kind !== exp_id.error_kind) begin
               $error("error_kind mismatch: expected %0d, actual %0d",
                      exp_id.error_kind, rsp_error_kind);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Watchdog: too long without a transfer on either side ends the run
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

endmodule
